>>> rtl/core/sacf_pkg.sv
// shared constants, types and transaction structs of the sparse accumulator
// column flush unit; no dependencies
`default_nettype none

package sacf_pkg;

    localparam int unsigned MAX_ROWS    = 64;
    localparam int unsigned MAX_OUTPUTS = 65536;

    localparam int unsigned ADDR_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned ROW_W   = 6;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned POS_W   = 16;

    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);

    localparam int unsigned POS_CAP_I =
        ((MAX_OUTPUTS - 1) > 65535) ? 65535 : (MAX_OUTPUTS - 1);
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_FLUSH      = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              clr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } t_wr_req;

    typedef struct packed {
        logic             has_entry;
        logic [ROW_W-1:0] out_row;
        logic [VAL_W-1:0] out_value;
        logic [CNT_W-1:0] column_count;
        logic [POS_W-1:0] out_position;
        logic             position_overflow;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/sacf_acc_mem.sv
// accumulator store: one synchronous read port, one write port, per-row valid bits
// an entry that is not valid reads with o_rd_vld low and is taken as zero by readers; depends on sacf_pkg
`default_nettype none

module sacf_acc_mem (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire sacf_pkg::t_rd_req           i_rd,
    input  wire sacf_pkg::t_wr_req           i_wr,
    output logic [sacf_pkg::VAL_W-1:0]       o_rd_data,
    output logic                             o_rd_vld
);

    logic [sacf_pkg::VAL_W-1:0] r_mem [sacf_pkg::MAX_ROWS];
    logic [sacf_pkg::MAX_ROWS-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            o_rd_data <= r_mem[i_rd.addr];
            o_rd_vld  <= r_vld[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en && i_rd.clr) begin
                r_vld[i_rd.addr] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sacf_mac.sv
// multiply-accumulate stage: registered product, read-modify-write of one row,
// forwarding of the previous write; depends on sacf_pkg
`default_nettype none

module sacf_mac (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_issue,
    input  wire  [sacf_pkg::ADDR_W-1:0]       i_addr,
    input  wire  [sacf_pkg::VAL_W-1:0]        i_a_value,
    input  wire  [sacf_pkg::VAL_W-1:0]        i_b_value,
    input  wire  [sacf_pkg::VAL_W-1:0]        i_rd_data,
    input  wire                               i_rd_vld,
    output sacf_pkg::t_wr_req                 o_wr
);

    logic                        r_av;
    logic [sacf_pkg::ADDR_W-1:0] r_addr;
    logic [sacf_pkg::VAL_W-1:0]  r_prod;
    logic                        r_fv;
    logic [sacf_pkg::ADDR_W-1:0] r_faddr;
    logic [sacf_pkg::VAL_W-1:0]  r_fdata;
    logic [sacf_pkg::VAL_W-1:0]  old_val;
    logic [sacf_pkg::VAL_W-1:0]  n_sum;

    always_comb begin
        priority if (r_fv && (r_faddr == r_addr)) begin
            old_val = r_fdata;
        end else if (i_rd_vld) begin
            old_val = i_rd_data;
        end else begin
            old_val = '0;
        end
        n_sum = old_val + r_prod;
        o_wr  = '{en: r_av, addr: r_addr, data: n_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_fv <= 1'b0;
        end else begin
            r_av <= i_issue;
            r_fv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_addr <= i_addr;
            r_prod <= i_a_value * i_b_value;
        end
        if (r_av) begin
            r_faddr <= r_addr;
            r_fdata <= n_sum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sacf_scan.sv
// column flush sequencer: row scan over the store, bias add, one-entry lookahead
// for the last flag, output position counter and output register; depends on sacf_pkg
`default_nettype none

module sacf_scan (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire  [sacf_pkg::VAL_W-1:0]        i_bias,
    input  wire  [sacf_pkg::CNT_W-1:0]        i_rows_in_use,
    input  wire  [sacf_pkg::VAL_W-1:0]        i_rd_data,
    input  wire                               i_rd_vld,
    output sacf_pkg::t_rd_req                 o_rd,
    output logic                              o_busy,
    output sacf_pkg::t_result                 o_result,
    output logic                              o_valid,
    input  wire                               i_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [sacf_pkg::CNT_W-1:0]  r_len;
    logic [sacf_pkg::CNT_W-1:0]  r_iss;
    logic [sacf_pkg::VAL_W-1:0]  r_bias;
    logic                        r_bv;
    logic [sacf_pkg::ADDR_W-1:0] r_bi;
    logic [sacf_pkg::CNT_W-1:0]  r_cnt;
    logic [sacf_pkg::POS_W-1:0]  r_pos;
    logic                        r_sat;
    logic                        r_pv;
    sacf_pkg::t_result           r_pend;
    sacf_pkg::t_result           r_out;
    logic                        r_ovalid;

    logic [sacf_pkg::VAL_W-1:0]  b_val;
    logic [sacf_pkg::VAL_W-1:0]  b_sum;
    logic                        b_emit;
    logic                        o_free;
    logic                        stall;
    logic                        issue;
    logic                        scan_end;
    logic                        load_pend;
    logic                        load_done;
    sacf_pkg::t_result           n_cand;
    sacf_pkg::t_result           n_final;
    logic [sacf_pkg::CNT_W-1:0]  start_len;

    always_comb begin
        o_free   = !r_ovalid || i_ready;
        b_val    = i_rd_vld ? i_rd_data : '0;
        b_sum    = b_val + r_bias;
        b_emit   = r_bv && (b_val != '0) && (b_sum != '0);
        stall    = b_emit && r_pv && !o_free;
        issue    = (r_state == S_SCAN) && (r_iss < r_len) && !stall;
        scan_end = (r_state == S_SCAN) && (r_iss == r_len) && !stall;
        load_pend = (r_state == S_SCAN) && b_emit && !stall;
        load_done = (r_state == S_DONE) && o_free;
        start_len = (i_rows_in_use > sacf_pkg::MAX_ROWS_C) ? sacf_pkg::MAX_ROWS_C
                                                           : i_rows_in_use;
        o_rd = '{en: issue, addr: r_iss[sacf_pkg::ADDR_W-1:0], clr: 1'b1};

        n_cand = '{has_entry: 1'b1,
                   out_row: sacf_pkg::ROW_W'(r_bi),
                   out_value: b_sum,
                   column_count: r_cnt + 1'b1,
                   out_position: r_pos,
                   position_overflow: r_sat,
                   last: 1'b0};

        if (r_pv) begin
            n_final      = r_pend;
            n_final.last = 1'b1;
        end else begin
            n_final = '{has_entry: 1'b0, out_row: '0, out_value: '0,
                        column_count: '0, out_position: r_pos,
                        position_overflow: r_sat, last: 1'b1};
        end

        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SCAN;
            S_SCAN:  if (scan_end) n_state = S_DONE;
            S_DONE:  if (o_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_out;
    assign o_valid  = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_sat    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_bv <= 1'b0;
            end else if (!stall) begin
                r_bv <= issue;
            end
            if (load_pend) begin
                r_pv <= 1'b1;
                if (r_pos < sacf_pkg::POS_CAP) begin
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_sat <= 1'b1;
                end
            end else if (load_done) begin
                r_pv <= 1'b0;
            end
            if ((load_pend && r_pv) || load_done) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_len  <= start_len;
            r_iss  <= '0;
            r_bias <= i_bias;
            r_cnt  <= '0;
        end else if (issue) begin
            r_iss <= r_iss + 1'b1;
            r_bi  <= r_iss[sacf_pkg::ADDR_W-1:0];
        end
        if (load_pend) begin
            r_pend <= n_cand;
            r_cnt  <= r_cnt + 1'b1;
            if (r_pv) begin
                r_out <= r_pend;
            end
        end else if (load_done) begin
            r_out <= n_final;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sparse_accumulator_column_flush_unit.sv
// Sparse accumulator with column flush. Accumulate transactions are taken one per
// cycle while no flush runs and add a_value*b_value into the row's 32-bit accumulator
// through a two-stage read-modify-write of the accumulator store, with forwarding
// between back-to-back transactions. A flush transaction holds the input off while
// the single read port of the store walks rows 0 to rows_in_use-1, with rows_in_use
// capped at 64, at one row per cycle while the output side does not stall. Results
// leave through an output register, so the next transaction is accepted while the
// last one waits. The store clears at reset through per-row valid bits; there is no
// clearing pass. Depends on sacf_pkg, sacf_acc_mem, sacf_mac and sacf_scan.
`default_nettype none

module sparse_accumulator_column_flush_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // row[5:0], a_value[37:6], b_value[69:38], column_bias[101:70], zero pad
    input  wire  [103:0] i_s_tdata,
    // op[0]
    input  wire          i_s_tuser,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // out_row[5:0], out_value[37:6], column_count[44:38], out_position[60:45],
    // position_overflow[61], zero pad
    output logic [63:0]  o_m_tdata,
    // has_entry[0]
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    input  wire          i_cfg_wr_en,
    input  wire  [6:0]   i_cfg_wr_data
);

    logic [sacf_pkg::CNT_W-1:0] r_rows_in_use;
    logic                       s_fire;
    logic                       acc_issue;
    logic                       flush_start;
    logic                       scan_busy;
    logic [sacf_pkg::ROW_W-1:0] in_row;
    sacf_pkg::t_rd_req          scan_rd;
    sacf_pkg::t_rd_req          mem_rd;
    sacf_pkg::t_wr_req          mem_wr;
    logic [sacf_pkg::VAL_W-1:0] rd_data;
    logic                       rd_vld;
    sacf_pkg::t_result          result;
    logic                       out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= sacf_pkg::CNT_W'(64);
        end else if (i_cfg_wr_en) begin
            r_rows_in_use <= i_cfg_wr_data;
        end
    end

    always_comb begin
        in_row      = i_s_tdata[5:0];
        o_s_tready  = !scan_busy;
        s_fire      = i_s_tvalid && o_s_tready;
        acc_issue   = s_fire && (i_s_tuser == sacf_pkg::OP_ACCUMULATE) &&
                      ({1'b0, in_row} < sacf_pkg::MAX_ROWS_C);
        flush_start = s_fire && (i_s_tuser == sacf_pkg::OP_FLUSH);
        if (scan_busy) begin
            mem_rd = scan_rd;
        end else begin
            mem_rd = '{en: acc_issue, addr: in_row[sacf_pkg::ADDR_W-1:0], clr: 1'b0};
        end
    end

    sacf_acc_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (mem_rd),
        .i_wr      (mem_wr),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld)
    );

    sacf_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (acc_issue),
        .i_addr    (in_row[sacf_pkg::ADDR_W-1:0]),
        .i_a_value (i_s_tdata[37:6]),
        .i_b_value (i_s_tdata[69:38]),
        .i_rd_data (rd_data),
        .i_rd_vld  (rd_vld),
        .o_wr      (mem_wr)
    );

    sacf_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (flush_start),
        .i_bias        (i_s_tdata[101:70]),
        .i_rows_in_use (r_rows_in_use),
        .i_rd_data     (rd_data),
        .i_rd_vld      (rd_vld),
        .o_rd          (scan_rd),
        .o_busy        (scan_busy),
        .o_result      (result),
        .o_valid       (out_valid),
        .i_ready       (i_m_tready)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tuser  = result.has_entry;
    assign o_m_tlast  = result.last;
    assign o_m_tdata  = {2'b00, result.position_overflow, result.out_position,
                         result.column_count, result.out_value, result.out_row};

endmodule

`default_nettype wire
